/* rtl/rigid_body_euler_step_core_macros.svh */
// Assertion macros shared by the euler step core.
`ifndef RIGID_BODY_EULER_STEP_CORE_MACROS_SVH
`define RIGID_BODY_EULER_STEP_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define RBE_CHECK(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RBE_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rbe_pkg.sv */
// Types, register codes and saturation helpers of the euler step core.
`timescale 1ns / 1ps
package rbe_pkg;

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;

   localparam logic [2:0] REG_ENABLED        = 3'd0;
   localparam logic [2:0] REG_USE_GRAVITY    = 3'd1;
   localparam logic [2:0] REG_GRAVITY_ACCEL  = 3'd2;
   localparam logic [2:0] REG_BODY_MASS      = 3'd3;
   localparam logic [2:0] REG_MAX_XZ_SPEED   = 3'd4;
   localparam logic [2:0] REG_MAX_FALL_SPEED = 3'd5;

   localparam logic [30:0] BODY_MASS_RESET = 31'd65536;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_accel_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] step_x;
      logic signed [31:0] step_y;
      logic signed [31:0] step_z;
   } rsp_type;

   typedef struct packed {
      logic        enabled;
      logic        use_gravity;
      logic [30:0] gravity_accel;
      logic [30:0] body_mass;
      logic [30:0] max_xz_speed;
      logic [30:0] max_fall_speed;
   } cfg_type;

   // what rides alongside the sqrt and divide pipes
   typedef struct packed {
      logic               valid;
      logic               xz_clamp;
      logic [16:0]        dt;
      logic signed [31:0] accel_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } side_type;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      if (s[32] != s[31]) begin
         return s[32] ? S32_MIN : S32_MAX;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      return sat33(33'(a) + 33'(b));
   endfunction

   // floor(p / 2^16) saturated to 32 bits
   function automatic logic signed [31:0] sat_q(input logic signed [49:0] p);
      logic signed [33:0] sh;
      sh = p[49:16];
      if (sh[33:31] == 3'b000 || sh[33:31] == 3'b111) begin
         return sh[31:0];
      end
      return sh[33] ? S32_MIN : S32_MAX;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      return a[31] ? (~a + 32'd1) : a;
   endfunction

endpackage

/* rtl/rbe_csr.sv */
// APB register file of the euler step core.
`timescale 1ns / 1ps
module rbe_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output rbe_pkg::cfg_type cfg
);

   rbe_pkg::cfg_type cfg_ff;
   logic             wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled        <= 1'b0;
         cfg_ff.use_gravity    <= 1'b0;
         cfg_ff.gravity_accel  <= '0;
         cfg_ff.body_mass      <= rbe_pkg::BODY_MASS_RESET;
         cfg_ff.max_xz_speed   <= '0;
         cfg_ff.max_fall_speed <= '0;
      end else if (wr) begin
         case (paddr[4:2])
            rbe_pkg::REG_ENABLED:        cfg_ff.enabled        <= pwdata[0];
            rbe_pkg::REG_USE_GRAVITY:    cfg_ff.use_gravity    <= pwdata[0];
            rbe_pkg::REG_GRAVITY_ACCEL:  cfg_ff.gravity_accel  <= pwdata[30:0];
            rbe_pkg::REG_BODY_MASS:      cfg_ff.body_mass      <= pwdata[30:0];
            rbe_pkg::REG_MAX_XZ_SPEED:   cfg_ff.max_xz_speed   <= pwdata[30:0];
            rbe_pkg::REG_MAX_FALL_SPEED: cfg_ff.max_fall_speed <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         rbe_pkg::REG_ENABLED:        prdata = {31'd0, cfg_ff.enabled};
         rbe_pkg::REG_USE_GRAVITY:    prdata = {31'd0, cfg_ff.use_gravity};
         rbe_pkg::REG_GRAVITY_ACCEL:  prdata = {1'b0, cfg_ff.gravity_accel};
         rbe_pkg::REG_BODY_MASS:      prdata = {1'b0, cfg_ff.body_mass};
         rbe_pkg::REG_MAX_XZ_SPEED:   prdata = {1'b0, cfg_ff.max_xz_speed};
         rbe_pkg::REG_MAX_FALL_SPEED: prdata = {1'b0, cfg_ff.max_fall_speed};
         default:                     prdata = '0;
      endcase
   end

endmodule

/* rtl/rbe_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module rbe_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);

   logic [31:0] rem_ff  [rbe_pkg::SQRT_STAGES];
   logic [31:0] root_ff [rbe_pkg::SQRT_STAGES];
   logic [63:0] rad_ff  [rbe_pkg::SQRT_STAGES];

   for (genvar k = 0; k < rbe_pkg::SQRT_STAGES; k++) begin : g_stage
      logic [31:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] rad_p;
      logic [33:0] rem_sh;
      logic [33:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
      end

      assign rem_sh = {rem_p, rad_p[63:62]};
      assign trial  = {root_p, 2'b01};
      assign ge     = rem_sh >= trial;

      // remainder stays within twice the partial root, so 32 bits hold it
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
            root_ff[k] <= {root_p[30:0], ge};
            rad_ff[k]  <= {rad_p[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[rbe_pkg::SQRT_STAGES-1];

endmodule

/* rtl/rbe_div.sv */
// Pipelined restoring divider, quotient known to fit 31 bits.
`timescale 1ns / 1ps
module rbe_div (
   input  logic        clock,
   input  logic        en,
   input  logic [61:0] num,
   input  logic [31:0] den,
   output logic [30:0] quo
);

   logic [31:0] rem_ff [rbe_pkg::DIV_STAGES];
   logic [30:0] low_ff [rbe_pkg::DIV_STAGES];
   logic [30:0] q_ff   [rbe_pkg::DIV_STAGES];
   logic [31:0] den_ff [rbe_pkg::DIV_STAGES];

   for (genvar k = 0; k < rbe_pkg::DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_p;
      logic [30:0] low_p;
      logic [30:0] q_p;
      logic [31:0] den_p;
      logic [32:0] rem_sh;
      logic        ge;

      // upper dividend bits are already below the divisor
      if (k == 0) begin : g_first
         assign rem_p = {1'b0, num[61:31]};
         assign low_p = num[30:0];
         assign q_p   = '0;
         assign den_p = den;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign low_p = low_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign den_p = den_ff[k-1];
      end

      assign rem_sh = {rem_p, low_p[30]};
      assign ge     = rem_sh >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? 32'(rem_sh - {1'b0, den_p}) : rem_sh[31:0];
            low_ff[k] <= {low_p[29:0], 1'b0};
            q_ff[k]   <= {q_p[29:0], ge};
            den_ff[k] <= den_p;
         end
      end
   end

   assign quo = q_ff[rbe_pkg::DIV_STAGES-1];

endmodule

/* rtl/rbe_skid.sv */
// Two-word output buffer between the pipeline and the result channel.
`timescale 1ns / 1ps
module rbe_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbe_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbe_pkg::rsp_type rsp_data
);

   rbe_pkg::rsp_type mem_ff [2];
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             wr_ff;
   logic             rd_ff;
   logic             pop;

   assign rsp_valid = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = mem_ff[rd_ff];
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/rigid_body_euler_step_core.sv */
// Top level of the rigid body euler step core.
`timescale 1ns / 1ps
// Usage:
// Each req word carries one body's acceleration, velocity, position and time
// step; each rsp word carries the updated vertical acceleration, velocity,
// position and the step taken. While the enabled register is 0 an accepted
// word gives no result. Registers sit on the APB port; the user must write
// them only while the block is idle, as the block itself does not enforce it.
// Throughput: one word per cycle while req_stall is low. Pipeline: 7
// arithmetic stages, a 32-stage square root, a scaling multiply, a 31-stage
// divider and 4 stages of position update.
// Results land in a two-word output buffer; the pipeline freezes only when
// that buffer is full, and then req_stall is high. A stalled rsp word holds.
// Reset (synchronous) clears all valid bits and the buffer and sets the
// registers to their defaults; the first word can be taken right after.
module rigid_body_euler_step_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbe_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

`include "rigid_body_euler_step_core_macros.svh"

   rbe_pkg::cfg_type cfg;
   logic             full;
   logic             en;

   rbe_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg)
   );

   assign en        = !full;
   assign req_stall = full;

   // stage 1: capture, gravity product
   logic             v1_ff;
   rbe_pkg::req_type d1_ff;
   logic [61:0]      gp1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid && cfg.enabled;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= req_data;
         gp1_ff <= 62'(cfg.gravity_accel) * 62'(cfg.body_mass);
      end
   end

   // stage 2: gravity term on vertical acceleration
   logic             v2_ff;
   rbe_pkg::req_type d2_ff;
   rbe_pkg::req_type d2_in;
   logic [45:0]      g_term;
   logic [30:0]      g_cap;

   assign g_term = gp1_ff[61:16];
   assign g_cap  = (g_term > 46'(cfg.max_fall_speed)) ? cfg.max_fall_speed : g_term[30:0];

   always_comb begin
      d2_in = d1_ff;
      if (cfg.use_gravity) begin
         d2_in.accel_y = rbe_pkg::sat33($signed({d1_ff.accel_y[31], d1_ff.accel_y})
                                        - $signed({2'b00, g_cap}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= d2_in;
      end
   end

   // stage 3: accel * dt
   logic                v3_ff;
   rbe_pkg::req_type    d3_ff;
   logic signed [49:0]  pa3_ff [3];
   logic signed [49:0]  dt2;

   assign dt2 = 50'($signed({1'b0, d2_ff.time_step}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d3_ff     <= d2_ff;
         pa3_ff[0] <= 50'(d2_ff.accel_x) * dt2;
         pa3_ff[1] <= 50'(d2_ff.accel_y) * dt2;
         pa3_ff[2] <= 50'(d2_ff.accel_z) * dt2;
      end
   end

   // stage 4: scale back to Q16.16
   logic                v4_ff;
   rbe_pkg::req_type    d4_ff;
   logic signed [31:0]  qa4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d4_ff <= d3_ff;
         for (int i = 0; i < 3; i++) begin
            qa4_ff[i] <= rbe_pkg::sat_q(pa3_ff[i]);
         end
      end
   end

   // stage 5: integrate velocity
   logic             v5_ff;
   rbe_pkg::req_type d5_ff;
   rbe_pkg::req_type d5_in;

   always_comb begin
      d5_in       = d4_ff;
      d5_in.vel_x = rbe_pkg::sat_sum(d4_ff.vel_x, qa4_ff[0]);
      d5_in.vel_y = rbe_pkg::sat_sum(d4_ff.vel_y, qa4_ff[1]);
      d5_in.vel_z = rbe_pkg::sat_sum(d4_ff.vel_z, qa4_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d5_ff <= d5_in;
      end
   end

   // stage 6: squares for both clamps
   logic             v6_ff;
   rbe_pkg::req_type d6_ff;
   logic [63:0]      sx6_ff;
   logic [63:0]      sz6_ff;
   logic [63:0]      sy6_ff;
   logic [61:0]      ll6_ff;
   logic [61:0]      fsq6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d6_ff   <= d5_ff;
         sx6_ff  <= 64'(rbe_pkg::mag32(d5_ff.vel_x)) * 64'(rbe_pkg::mag32(d5_ff.vel_x));
         sz6_ff  <= 64'(rbe_pkg::mag32(d5_ff.vel_z)) * 64'(rbe_pkg::mag32(d5_ff.vel_z));
         sy6_ff  <= 64'(rbe_pkg::mag32(d5_ff.vel_y)) * 64'(rbe_pkg::mag32(d5_ff.vel_y));
         ll6_ff  <= 62'(cfg.max_xz_speed) * 62'(cfg.max_xz_speed);
         fsq6_ff <= 62'(cfg.max_fall_speed) * 62'(cfg.max_fall_speed);
      end
   end

   // stage 7: clamp decisions, vertical clamp applied
   rbe_pkg::side_type  s7_ff;
   logic [63:0]        lsq7_ff;
   logic [63:0]        lsq;
   logic signed [31:0] fall_pos;
   logic signed [31:0] vy7;

   assign lsq      = sx6_ff + sz6_ff;
   assign fall_pos = $signed({1'b0, cfg.max_fall_speed});

   always_comb begin
      if (sy6_ff >= 64'(fsq6_ff)) begin
         vy7 = (d6_ff.vel_y > 32'sd0) ? fall_pos : -fall_pos;
      end else begin
         vy7 = d6_ff.vel_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ff.valid <= 1'b0;
      end else if (en) begin
         s7_ff.valid <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ff.xz_clamp <= (lsq >= 64'(ll6_ff)) && (lsq != 64'd0);
         s7_ff.dt       <= d6_ff.time_step;
         s7_ff.accel_y  <= d6_ff.accel_y;
         s7_ff.vel_x    <= d6_ff.vel_x;
         s7_ff.vel_y    <= vy7;
         s7_ff.vel_z    <= d6_ff.vel_z;
         s7_ff.pos_x    <= d6_ff.pos_x;
         s7_ff.pos_y    <= d6_ff.pos_y;
         s7_ff.pos_z    <= d6_ff.pos_z;
         lsq7_ff        <= lsq;
      end
   end

   // square root of the XZ length squared
   logic [31:0]       root;
   rbe_pkg::side_type sd_ff [rbe_pkg::SQRT_STAGES];

   rbe_sqrt u_sqrt (
      .clock(clock),
      .en   (en),
      .rad  (lsq7_ff),
      .root (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rbe_pkg::SQRT_STAGES; k++) begin
            sd_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         sd_ff[0] <= s7_ff;
         for (int k = 1; k < rbe_pkg::SQRT_STAGES; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // stage 8: |c| * limit
   rbe_pkg::side_type sqo;
   rbe_pkg::side_type s8_ff;
   logic [61:0]       nx8_ff;
   logic [61:0]       nz8_ff;
   logic [31:0]       r8_ff;

   assign sqo = sd_ff[rbe_pkg::SQRT_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ff.valid <= 1'b0;
      end else if (en) begin
         s8_ff <= sqo;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx8_ff <= 62'(rbe_pkg::mag32(sqo.vel_x)) * 62'(cfg.max_xz_speed);
         nz8_ff <= 62'(rbe_pkg::mag32(sqo.vel_z)) * 62'(cfg.max_xz_speed);
         r8_ff  <= root;
      end
   end

   // divide by the root
   logic [30:0]       quo_x;
   logic [30:0]       quo_z;
   rbe_pkg::side_type dd_ff [rbe_pkg::DIV_STAGES];

   rbe_div u_div_x (
      .clock(clock),
      .en   (en),
      .num  (nx8_ff),
      .den  (r8_ff),
      .quo  (quo_x)
   );

   rbe_div u_div_z (
      .clock(clock),
      .en   (en),
      .num  (nz8_ff),
      .den  (r8_ff),
      .quo  (quo_z)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rbe_pkg::DIV_STAGES; k++) begin
            dd_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         dd_ff[0] <= s8_ff;
         for (int k = 1; k < rbe_pkg::DIV_STAGES; k++) begin
            dd_ff[k] <= dd_ff[k-1];
         end
      end
   end

   // stage 9: apply XZ rescale
   rbe_pkg::side_type  dvo;
   rbe_pkg::side_type  s9_ff;
   rbe_pkg::side_type  s9_in;
   logic signed [31:0] qx_s;
   logic signed [31:0] qz_s;
   logic               quo_ok;

   assign dvo    = dd_ff[rbe_pkg::DIV_STAGES-1];
   assign qx_s   = $signed({1'b0, quo_x});
   assign qz_s   = $signed({1'b0, quo_z});
   assign quo_ok = (quo_x <= cfg.max_xz_speed) && (quo_z <= cfg.max_xz_speed);

   always_comb begin
      s9_in = dvo;
      if (dvo.xz_clamp) begin
         s9_in.vel_x = dvo.vel_x[31] ? -qx_s : qx_s;
         s9_in.vel_z = dvo.vel_z[31] ? -qz_s : qz_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_ff.valid <= 1'b0;
      end else if (en) begin
         s9_ff <= s9_in;
      end
   end

   // stage 10: velocity * dt
   rbe_pkg::side_type  s10_ff;
   logic signed [49:0] pv10_ff [3];
   logic signed [49:0] dt9;

   assign dt9 = 50'($signed({1'b0, s9_ff.dt}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_ff.valid <= 1'b0;
      end else if (en) begin
         s10_ff <= s9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pv10_ff[0] <= 50'(s9_ff.vel_x) * dt9;
         pv10_ff[1] <= 50'(s9_ff.vel_y) * dt9;
         pv10_ff[2] <= 50'(s9_ff.vel_z) * dt9;
      end
   end

   // stage 11: step in Q16.16
   rbe_pkg::side_type  s11_ff;
   logic signed [31:0] st11_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_ff.valid <= 1'b0;
      end else if (en) begin
         s11_ff <= s10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            st11_ff[i] <= rbe_pkg::sat_q(pv10_ff[i]);
         end
      end
   end

   // stage 12: advance position, form the result word
   logic             v12_ff;
   rbe_pkg::rsp_type r12_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
      end else if (en) begin
         v12_ff <= s11_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r12_ff.new_accel_y <= s11_ff.accel_y;
         r12_ff.new_vel_x   <= s11_ff.vel_x;
         r12_ff.new_vel_y   <= s11_ff.vel_y;
         r12_ff.new_vel_z   <= s11_ff.vel_z;
         r12_ff.new_pos_x   <= rbe_pkg::sat_sum(s11_ff.pos_x, st11_ff[0]);
         r12_ff.new_pos_y   <= rbe_pkg::sat_sum(s11_ff.pos_y, st11_ff[1]);
         r12_ff.new_pos_z   <= rbe_pkg::sat_sum(s11_ff.pos_z, st11_ff[2]);
         r12_ff.step_x      <= st11_ff[0];
         r12_ff.step_y      <= st11_ff[1];
         r12_ff.step_z      <= st11_ff[2];
      end
   end

   rbe_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .push     (v12_ff && en),
      .push_data(r12_ff),
      .full     (full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   `RBE_CHECK(a_root_nonzero, sqo.valid && sqo.xz_clamp, root != 32'd0, "root zero on clamp")
   `RBE_CHECK(a_quo_bound, dvo.valid && dvo.xz_clamp, quo_ok, "rescaled speed above limit")
   `RBE_CHECK(a_stall_has_rsp, req_stall, rsp_valid, "input stalled with no word waiting")
   `RBE_NEXT(a_stall_release, req_stall && !rsp_stall, !req_stall, "buffer did not drain")

endmodule
